@@ design/tsr_pkg.sv @@
// Shared types and constants for the stream reassembler.
package tsr_pkg;

    // Fixed widths of the item fields.
    localparam int unsigned IDX_W   = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned COUNT_W = 7;

    // Input item codes.
    localparam logic [1:0] MODE_DATA = 2'd0;
    localparam logic [1:0] MODE_END  = 2'd1;
    localparam logic [1:0] MODE_FREE = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [IDX_W-1:0]   stream_index;
        logic [BYTE_W-1:0]  data_byte;
        logic               final_flag;
        logic [COUNT_W-1:0] free_count;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]  out_byte;
        logic               byte_valid;
        logic               last_of_run;
        logic [COUNT_W-1:0] pending_count;
        logic               stream_closed;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_INSERT,
        ST_SCAN,
        ST_CLOSE,
        ST_READ,
        ST_EMIT,
        ST_STATUS
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Commands from the sequencer to the byte store.
    typedef struct packed {
        logic write;
        logic clear;
        logic read;
    } store_cmd_t;

endpackage

@@ design/tsr_alu.sv @@
// Shared 64-bit adder/subtractor used by the sequencer for every index calculation.
module tsr_alu
(
    input  tsr_pkg::alu_op_t               op,
    input  logic [tsr_pkg::IDX_W-1:0]      a,
    input  logic [tsr_pkg::IDX_W-1:0]      b,
    output logic [tsr_pkg::IDX_W-1:0]      sum
);

    logic [tsr_pkg::IDX_W-1:0] b_eff;

    // Subtraction is addition of the inverted operand with a carry in.
    assign b_eff = (op == tsr_pkg::ALU_SUB) ? ~b : b;
    assign sum   = a + b_eff + tsr_pkg::IDX_W'(op == tsr_pkg::ALU_SUB);

endmodule

@@ design/tsr_store.sv @@
// Ring store of stream bytes with a valid bit per slot.
module tsr_store
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  tsr_pkg::store_cmd_t         cmd,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [tsr_pkg::BYTE_W-1:0]  wr_data,
    input  logic [$clog2(DEPTH)-1:0]    clr_addr,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    input  logic [$clog2(DEPTH)-1:0]    look_a_addr,
    input  logic [$clog2(DEPTH)-1:0]    look_b_addr,
    output logic [tsr_pkg::BYTE_W-1:0]  rd_data,
    output logic                        look_a,
    output logic                        look_b
);

    logic [tsr_pkg::BYTE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic [tsr_pkg::BYTE_W-1:0] rd_data_reg;

    // Byte memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.read)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits are set on a write and cleared when the byte drains.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (cmd.write)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (cmd.clear)
            begin
                valid_reg[clr_addr] <= 1'b0;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign look_a  = valid_reg[look_a_addr];
    assign look_b  = valid_reg[look_b_addr];

endmodule

@@ design/tcp_stream_reassembler.sv @@
// Top level of the stream reassembler: sequencer, window state and output register.
//
// Reassembles a byte stream from bytes that arrive in any order, each tagged with its
// absolute stream index, in a ring of BUFFER_DEPTH slots. The block handles one item
// at a time and holds item_ready low while it works. An end marker, a space-freed item
// or an unused mode code passes through decode and close before its status result; a
// data byte also passes through insert, whether it is dropped or stored, and a stored
// byte also scans. A data byte that releases n contiguous bytes gives n results, one
// per released byte. The scan tests the valid bits at one slot per cycle, and each
// released byte then takes a read of the byte memory's one read port and a 64-bit
// stream count update on the one shared adder. item_ready returns in the cycle after
// the last result is loaded. A result can wait in the output register while the
// sequencer prepares the next one; only a result that is ready to load while the
// register is still full adds stall cycles.
module tcp_stream_reassembler
#(
    parameter int unsigned BUFFER_DEPTH = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  tsr_pkg::in_item_t  item,
    output logic               result_valid,
    input  logic               result_ready,
    output tsr_pkg::out_item_t result
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned CW = $clog2(BUFFER_DEPTH + 1);
    localparam int unsigned SW = AW + 1;

    tsr_pkg::state_t            state_reg, state_next;
    tsr_pkg::in_item_t          item_reg, item_next;
    logic [tsr_pkg::IDX_W-1:0]  off_reg, off_next;
    logic [tsr_pkg::IDX_W-1:0]  pushed_reg, pushed_next;
    logic [tsr_pkg::IDX_W-1:0]  end_reg, end_next;
    logic                       end_known_reg, end_known_next;
    logic [CW-1:0]              used_reg, used_next;
    logic [CW-1:0]              pending_reg, pending_next;
    logic                       closed_reg, closed_next;
    logic [AW-1:0]              head_reg, head_next;
    logic [AW-1:0]              scan_reg, scan_next;
    logic [CW-1:0]              cnt_reg, cnt_next;
    logic                       res_valid_reg, res_valid_next;
    tsr_pkg::out_item_t         res_reg, res_next;

    tsr_pkg::alu_op_t           alu_op;
    logic [tsr_pkg::IDX_W-1:0]  alu_a;
    logic [tsr_pkg::IDX_W-1:0]  alu_b;
    logic [tsr_pkg::IDX_W-1:0]  alu_sum;

    tsr_pkg::store_cmd_t        store_cmd;
    logic [tsr_pkg::BYTE_W-1:0] rd_data;
    logic                       ins_was_valid;
    logic                       scan_valid;

    logic [CW-1:0]              avail;
    logic                       win_ok;
    logic [SW-1:0]              ins_sum;
    logic [AW-1:0]              ins_slot;
    logic                       load_ok;
    logic [CW-1:0]              pend_dec;

    // Wrap a slot pointer at the end of the ring.
    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        logic [AW-1:0] r;
        begin
            if (p == AW'(BUFFER_DEPTH - 1))
            begin
                r = '0;
            end
            else
            begin
                r = p + 1'b1;
            end
            return r;
        end
    endfunction

    tsr_alu u_alu
    (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .sum (alu_sum)
    );

    tsr_store #(
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (store_cmd),
        .wr_addr     (ins_slot),
        .wr_data     (item_reg.data_byte),
        .clr_addr    (head_reg),
        .rd_addr     (head_reg),
        .look_a_addr (ins_slot),
        .look_b_addr (scan_reg),
        .rd_data     (rd_data),
        .look_a      (ins_was_valid),
        .look_b      (scan_valid)
    );

    // Window test and slot of the incoming byte; the offset is below the depth here.
    assign avail    = CW'(BUFFER_DEPTH) - used_reg;
    assign win_ok   = !closed_reg && (avail != '0)
                      && (off_reg[tsr_pkg::IDX_W-1:CW] == '0)
                      && (off_reg[CW-1:0] < avail);
    assign ins_sum  = SW'(head_reg) + SW'(off_reg[CW-1:0]);
    assign ins_slot = (ins_sum >= SW'(BUFFER_DEPTH)) ? AW'(ins_sum - SW'(BUFFER_DEPTH))
                                                     : AW'(ins_sum);
    assign load_ok  = !res_valid_reg || result_ready;
    assign pend_dec = (pending_reg != '0) ? pending_reg - 1'b1 : pending_reg;

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = tsr_pkg::ST_DECODE;
                end
            end
            tsr_pkg::ST_DECODE:
            begin
                if (item_reg.mode == tsr_pkg::MODE_DATA)
                begin
                    state_next = tsr_pkg::ST_INSERT;
                end
                else
                begin
                    state_next = tsr_pkg::ST_CLOSE;
                end
            end
            tsr_pkg::ST_INSERT:
            begin
                state_next = win_ok ? tsr_pkg::ST_SCAN : tsr_pkg::ST_CLOSE;
            end
            tsr_pkg::ST_SCAN:
            begin
                if (!(scan_valid && (cnt_reg < CW'(BUFFER_DEPTH))))
                begin
                    state_next = tsr_pkg::ST_CLOSE;
                end
            end
            tsr_pkg::ST_CLOSE:
            begin
                state_next = (cnt_reg != '0) ? tsr_pkg::ST_READ : tsr_pkg::ST_STATUS;
            end
            tsr_pkg::ST_READ:
            begin
                state_next = tsr_pkg::ST_EMIT;
            end
            tsr_pkg::ST_EMIT:
            begin
                if (load_ok)
                begin
                    state_next = (cnt_reg == CW'(1)) ? tsr_pkg::ST_IDLE : tsr_pkg::ST_READ;
                end
            end
            tsr_pkg::ST_STATUS:
            begin
                if (load_ok)
                begin
                    state_next = tsr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tsr_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: shared adder operands and store commands.
    always_comb
    begin
        item_ready = 1'b0;
        alu_op     = tsr_pkg::ALU_SUB;
        alu_a      = item_reg.stream_index;
        alu_b      = pushed_reg;
        store_cmd  = '0;
        unique case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
            end
            tsr_pkg::ST_DECODE:
            begin
                // Offset of the byte from the stream head.
                alu_op = tsr_pkg::ALU_SUB;
                alu_a  = item_reg.stream_index;
                alu_b  = pushed_reg;
            end
            tsr_pkg::ST_INSERT:
            begin
                // End position one past a final byte.
                alu_op          = tsr_pkg::ALU_ADD;
                alu_a           = item_reg.stream_index;
                alu_b           = tsr_pkg::IDX_W'(1);
                store_cmd.write = win_ok;
            end
            tsr_pkg::ST_CLOSE:
            begin
                // Distance from the head to the end position.
                alu_op = tsr_pkg::ALU_SUB;
                alu_a  = end_reg;
                alu_b  = pushed_reg;
            end
            tsr_pkg::ST_READ:
            begin
                store_cmd.read = 1'b1;
            end
            tsr_pkg::ST_EMIT:
            begin
                alu_op          = tsr_pkg::ALU_ADD;
                alu_a           = pushed_reg;
                alu_b           = tsr_pkg::IDX_W'(1);
                store_cmd.clear = load_ok;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // Datapath register updates.
    always_comb
    begin
        item_next      = item_reg;
        off_next       = off_reg;
        pushed_next    = pushed_reg;
        end_next       = end_reg;
        end_known_next = end_known_reg;
        used_next      = used_reg;
        pending_next   = pending_reg;
        closed_next    = closed_reg;
        head_next      = head_reg;
        scan_next      = scan_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;

        if (res_valid_reg && result_ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            tsr_pkg::ST_IDLE:
            begin
                if (item_valid)
                begin
                    item_next = item;
                    cnt_next  = '0;
                end
            end
            tsr_pkg::ST_DECODE:
            begin
                off_next = alu_sum;
                if (item_reg.mode == tsr_pkg::MODE_END)
                begin
                    if (!end_known_reg)
                    begin
                        end_next       = item_reg.stream_index;
                        end_known_next = 1'b1;
                    end
                end
                else if (item_reg.mode == tsr_pkg::MODE_FREE)
                begin
                    // Space freed downstream; the count saturates at zero.
                    if (item_reg.free_count >= tsr_pkg::COUNT_W'(used_reg))
                    begin
                        used_next = '0;
                    end
                    else
                    begin
                        used_next = used_reg - CW'(item_reg.free_count);
                    end
                end
            end
            tsr_pkg::ST_INSERT:
            begin
                scan_next = head_reg;
                if (win_ok)
                begin
                    if (item_reg.final_flag && !end_known_reg)
                    begin
                        end_next       = alu_sum;
                        end_known_next = 1'b1;
                    end
                    if (!ins_was_valid)
                    begin
                        pending_next = pending_reg + 1'b1;
                    end
                end
            end
            tsr_pkg::ST_SCAN:
            begin
                // Count the contiguous run of stored bytes from the head.
                if (scan_valid && (cnt_reg < CW'(BUFFER_DEPTH)))
                begin
                    cnt_next  = cnt_reg + 1'b1;
                    scan_next = ptr_inc(scan_reg);
                end
            end
            tsr_pkg::ST_CLOSE:
            begin
                // The stream closes if the head reaches the end after this run drains.
                if (end_known_reg && (alu_sum == tsr_pkg::IDX_W'(cnt_reg)))
                begin
                    closed_next = 1'b1;
                end
            end
            tsr_pkg::ST_EMIT:
            begin
                if (load_ok)
                begin
                    res_next.out_byte      = rd_data;
                    res_next.byte_valid    = 1'b1;
                    res_next.last_of_run   = (cnt_reg == CW'(1));
                    res_next.pending_count = tsr_pkg::COUNT_W'(pend_dec);
                    res_next.stream_closed = closed_reg;
                    res_valid_next         = 1'b1;
                    pending_next           = pend_dec;
                    pushed_next            = alu_sum;
                    head_next              = ptr_inc(head_reg);
                    cnt_next               = cnt_reg - 1'b1;
                    if (used_reg < CW'(BUFFER_DEPTH))
                    begin
                        used_next = used_reg + 1'b1;
                    end
                end
            end
            tsr_pkg::ST_STATUS:
            begin
                if (load_ok)
                begin
                    res_next.out_byte      = '0;
                    res_next.byte_valid    = 1'b0;
                    res_next.last_of_run   = 1'b1;
                    res_next.pending_count = tsr_pkg::COUNT_W'(pending_reg);
                    res_next.stream_closed = closed_reg;
                    res_valid_next         = 1'b1;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    // Control and stream state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tsr_pkg::ST_IDLE;
            pushed_reg    <= '0;
            end_reg       <= '0;
            end_known_reg <= 1'b0;
            used_reg      <= '0;
            pending_reg   <= '0;
            closed_reg    <= 1'b0;
            head_reg      <= '0;
            scan_reg      <= '0;
            cnt_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pushed_reg    <= pushed_next;
            end_reg       <= end_next;
            end_known_reg <= end_known_next;
            used_reg      <= used_next;
            pending_reg   <= pending_next;
            closed_reg    <= closed_next;
            head_reg      <= head_next;
            scan_reg      <= scan_next;
            cnt_reg       <= cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        off_reg  <= off_next;
        res_reg  <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule
